>>> design/complex_arithmetic_unit_assert.svh
// assertion macros shared by the complex arithmetic unit
// no dependencies; SYNTH drops the checks from synthesis builds
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CAU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("complex arithmetic unit assertion failed");
`define CAU_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("complex arithmetic unit assertion failed");
`else
`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> design/cau_pkg.sv
// types, constants and the saturation helper of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package cau_pkg;
  localparam int NCELL   = 34;
  localparam int QW      = 34;
  localparam int NW      = 81;
  localparam int DW      = 98;
  localparam int SW      = 68;
  localparam int LATENCY = 38;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_MAG = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;
  } cau_out_t;

  typedef struct packed {
    logic [NW-1:0] rre;
    logic [NW-1:0] rim;
    logic [64:0]   den;
    logic [QW-1:0] qre;
    logic [QW-1:0] qim;
    logic [SW-1:0] sx;
    logic [SW-1:0] sres;
  } cau_lane_t;

  typedef struct packed {
    logic     v;
    logic [2:0] func;
    logic     zdiv;
    logic     nre_neg;
    logic     nim_neg;
    cau_out_t fast;
  } cau_side_t;

  typedef struct packed {
    logic [31:0] w;
    logic        ovf;
  } sat_t;

  function automatic sat_t sat66(input logic signed [65:0] v);
    sat_t r;
    r.w   = v[31:0];
    r.ovf = 1'b0;
    if (v > 66'sd2147483647) begin
      r.w   = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r.w   = 32'h8000_0000;
      r.ovf = 1'b1;
    end
    return r;
  endfunction
endpackage

>>> design/complex_arithmetic_unit.sv
// complex add, subtract, multiply, divide and magnitude on Q16.16 operands
// every operation takes the same path of registers from the start beat to the done strobe
// throughput: one beat per clock; busy stays low
// latency is set by the 34-cell chain that forms quotient and root bits
// reset clears the valid bits only; the receiver cannot stall
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_in_t  op,
  output logic     done,
  output cau_out_t result
);
  logic    va;
  cau_in_t opa;

  logic               vb;
  logic [2:0]         fb;
  logic               zb;
  cau_out_t           asb;
  logic signed [63:0] pb0, pb1, pb2, pb3, pb4, pb5;

  logic signed [31:0] mb0, mb1;
  logic signed [32:0] sre, sim;
  sat_t               sre_s, sim_s;
  cau_out_t           as_n;

  logic signed [65:0] mre, mim, nre, nim;
  logic [65:0]        are, aim;
  sat_t               mre_s, mim_s;
  cau_side_t          side_n;
  cau_lane_t          lane_n;

  cau_side_t side [NCELL+1];
  cau_lane_t lane [NCELL+1];

  logic signed [65:0] qre, qim;
  sat_t               qre_s, qim_s, sq_s;
  cau_out_t           res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start;
    end
    opa <= op;
  end

  // products and add/sub
  always_comb begin
    mb0 = (opa.func == FUNC_MAG) ? opa.a_re : opa.b_re;
    mb1 = (opa.func == FUNC_MAG) ? opa.a_im : opa.b_im;
    sre = 33'(opa.a_re) + 33'(opa.b_re);
    sim = 33'(opa.a_im) + 33'(opa.b_im);
    if (opa.func == FUNC_SUB) begin
      sre = 33'(opa.a_re) - 33'(opa.b_re);
      sim = 33'(opa.a_im) - 33'(opa.b_im);
    end
    sre_s = sat66(66'(sre));
    sim_s = sat66(66'(sim));
    as_n.res_re = sre_s.w;
    as_n.res_im = sim_s.w;
    as_n.status = (sre_s.ovf || sim_s.ovf) ? ST_OVF : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    fb  <= opa.func;
    zb  <= (opa.b_re == 32'sd0) && (opa.b_im == 32'sd0);
    asb <= as_n;
    pb0 <= 64'(opa.a_re) * 64'(mb0);
    pb1 <= 64'(opa.a_im) * 64'(mb1);
    pb2 <= 64'(opa.a_re) * 64'(opa.b_im);
    pb3 <= 64'(opa.a_im) * 64'(opa.b_re);
    pb4 <= 64'(opa.b_re) * 64'(opa.b_re);
    pb5 <= 64'(opa.b_im) * 64'(opa.b_im);
  end

  // sums, multiply result and chain entry
  always_comb begin
    mre   = 66'(pb0) - 66'(pb1);
    mim   = 66'(pb2) + 66'(pb3);
    mre_s = sat66(mre >>> 16);
    mim_s = sat66(mim >>> 16);
    nre   = 66'(pb0) + 66'(pb1);
    nim   = 66'(pb3) - 66'(pb2);
    are   = nre[65] ? 66'(-nre) : 66'(nre);
    aim   = nim[65] ? 66'(-nim) : 66'(nim);

    side_n.v       = vb;
    side_n.func    = fb;
    side_n.zdiv    = zb;
    side_n.nre_neg = nre[65];
    side_n.nim_neg = nim[65];
    case (fb)
      FUNC_ADD, FUNC_SUB: side_n.fast = asb;
      FUNC_MUL: begin
        side_n.fast.res_re = mre_s.w;
        side_n.fast.res_im = mim_s.w;
        side_n.fast.status = (mre_s.ovf || mim_s.ovf) ? ST_OVF : ST_OK;
      end
      default: side_n.fast = '0;
    endcase

    lane_n.rre  = {are[64:0], 16'b0};
    lane_n.rim  = {aim[64:0], 16'b0};
    lane_n.den  = 65'($unsigned(pb4)) + 65'($unsigned(pb5));
    lane_n.qre  = '0;
    lane_n.qim  = '0;
    lane_n.sx   = SW'($unsigned(pb0)) + SW'($unsigned(pb1));
    lane_n.sres = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].v <= 1'b0;
    end else begin
      side[0] <= side_n;
    end
    lane[0] <= lane_n;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_chain
    cau_cell u_cell (
      .clk  (clk),
      .k    (6'(NCELL - 1 - i)),
      .lin  (lane[i]),
      .lout (lane[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].v <= 1'b0;
      end else begin
        side[i+1] <= side[i];
      end
    end
  end

  // sign, saturation and result select
  always_comb begin
    qre   = side[NCELL].nre_neg ? -66'(lane[NCELL].qre) : 66'(lane[NCELL].qre);
    qim   = side[NCELL].nim_neg ? -66'(lane[NCELL].qim) : 66'(lane[NCELL].qim);
    qre_s = sat66(qre);
    qim_s = sat66(qim);
    sq_s  = sat66($signed(lane[NCELL].sres[65:0]));
    case (side[NCELL].func)
      FUNC_DIV: begin
        if (side[NCELL].zdiv) begin
          res_next.res_re = '0;
          res_next.res_im = '0;
          res_next.status = ST_DIVZ;
        end else begin
          res_next.res_re = qre_s.w;
          res_next.res_im = qim_s.w;
          res_next.status = (qre_s.ovf || qim_s.ovf) ? ST_OVF : ST_OK;
        end
      end
      FUNC_MAG: begin
        res_next.res_re = sq_s.w;
        res_next.res_im = '0;
        res_next.status = sq_s.ovf ? ST_OVF : ST_OK;
      end
      default: res_next = side[NCELL].fast;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[NCELL].v;
    end
    result <= res_next;
  end

  `CAU_ASSERT(a_fixed_latency, clk, rst, start |-> ##LATENCY done)
  `CAU_ASSERT(a_divz_zero, clk, rst, (done && result.status == ST_DIVZ) |-> (result.res_re == 32'sd0 && result.res_im == 32'sd0))
  `CAU_ASSERT(a_status_code, clk, rst, done |-> (result.status != 2'd3))
  `CAU_ASSERT_NR(a_never_busy, clk, !busy)
endmodule

>>> design/cau_cell.sv
// one step cell: a quotient bit for both divides and a root bit for the magnitude
// depends on cau_pkg
`timescale 1ns / 1ps
module cau_cell import cau_pkg::*; (
  input  logic      clk,
  input  logic [5:0] k,
  input  cau_lane_t lin,
  output cau_lane_t lout
);
  logic [DW-1:0] dsh;
  logic [SW-1:0] one;
  logic [SW-1:0] t;
  cau_lane_t     nxt;

  always_comb begin
    dsh = DW'(lin.den) << k;
    one = SW'(1) << {k, 1'b0};
    t   = lin.sres + one;
    nxt = lin;
    // restoring step on the magnitudes, divisor shifted to this bit
    if (DW'(lin.rre) >= dsh) begin
      nxt.rre = lin.rre - NW'(dsh);
      nxt.qre = {lin.qre[QW-2:0], 1'b1};
    end else begin
      nxt.qre = {lin.qre[QW-2:0], 1'b0};
    end
    if (DW'(lin.rim) >= dsh) begin
      nxt.rim = lin.rim - NW'(dsh);
      nxt.qim = {lin.qim[QW-2:0], 1'b1};
    end else begin
      nxt.qim = {lin.qim[QW-2:0], 1'b0};
    end
    if (lin.sx >= t) begin
      nxt.sx   = lin.sx - t;
      nxt.sres = (lin.sres >> 1) + one;
    end else begin
      nxt.sres = lin.sres >> 1;
    end
  end

  always_ff @(posedge clk) begin
    lout <= nxt;
  end
endmodule
